// File: design/stcsl_pkg.sv
// Shared types and constants for the servo trim, clamp and slew limiter.
// Used by stcsl_channel and servo_trim_clamp_slew_limiter; depends on nothing.
package stcsl_pkg;

	// Field widths
	localparam int ANGLE_W = 16;
	localparam int DEG_W   = 10;
	localparam int STEP_W  = 24;

	// Position range, 1/64 degree
	localparam logic signed [ANGLE_W-1:0] POS_MAX = 16'sd23040;

	// Configuration register indexes
	localparam logic [2:0] REG_NEUTRAL    = 3'd0;
	localparam logic [2:0] REG_TRIM_LEFT  = 3'd1;
	localparam logic [2:0] REG_TRIM_RIGHT = 3'd2;
	localparam logic [2:0] REG_TRIM_PITCH = 3'd3;
	localparam logic [2:0] REG_DEFL_LIMIT = 3'd4;
	localparam logic [2:0] REG_SLEW_RATE  = 3'd5;
	localparam logic [2:0] REG_LIMITS_ON  = 3'd6;

	// Reset values
	localparam logic [13:0] NEUTRAL_RST    = 14'd5760;
	localparam logic [12:0] DEFL_LIMIT_RST = 13'd2560;
	localparam logic [15:0] SLEW_RATE_RST  = 16'd4915;
	localparam logic signed [ANGLE_W-1:0] HELD_RST = 16'sd5760;

	// Configuration register set
	typedef struct packed {
		logic        [13:0] neutral;
		logic signed [13:0] trim_left;
		logic signed [13:0] trim_right;
		logic signed [13:0] trim_pitch;
		logic        [12:0] deflection_limit;
		logic        [15:0] slew_rate;
		logic               limits_on;
	} cfg_t;

endpackage

// File: design/stcsl_channel.sv
// One servo channel: trim with saturation, clamp window, slew limit, degree rounding.
// Depends on stcsl_pkg.
module stcsl_channel (
	input  stcsl_pkg::cfg_t                               cfg,
	input  logic signed [stcsl_pkg::ANGLE_W-1:0]          cmd,
	input  logic signed [13:0]                            trim,
	input  logic signed [stcsl_pkg::ANGLE_W-1:0]          held,
	input  logic        [stcsl_pkg::STEP_W-1:0]           step,
	output logic signed [stcsl_pkg::ANGLE_W-1:0]          pos,
	output logic signed [stcsl_pkg::DEG_W-1:0]            deg
);

	logic signed [16:0] sum;
	logic signed [17:0] sat;
	logic signed [17:0] lo;
	logic signed [17:0] hi;
	logic signed [17:0] clamped;
	logic signed [25:0] change;
	logic signed [25:0] step_s;
	logic signed [25:0] held_ext;
	logic signed [25:0] moved;
	logic        [15:0] mag;
	logic        [15:0] mag_rnd;
	logic        [9:0]  deg_mag;

	// trim add, saturated to the position range
	always_comb begin
		sum = $signed({cmd[15], cmd}) + $signed({{3{trim[13]}}, trim});
		if (sum > $signed({stcsl_pkg::POS_MAX[15], stcsl_pkg::POS_MAX}))
			sat = 18'(stcsl_pkg::POS_MAX);
		else if (sum < -$signed({stcsl_pkg::POS_MAX[15], stcsl_pkg::POS_MAX}))
			sat = -18'(stcsl_pkg::POS_MAX);
		else
			sat = 18'(sum);
	end

	// clamp window around neutral
	always_comb begin
		lo = $signed({4'b0, cfg.neutral}) - $signed({5'b0, cfg.deflection_limit});
		hi = $signed({4'b0, cfg.neutral}) + $signed({5'b0, cfg.deflection_limit});
		if (sat < lo)
			clamped = lo;
		else if (sat > hi)
			clamped = hi;
		else
			clamped = sat;
	end

	// slew limit against the held position
	always_comb begin
		held_ext = 26'(held);
		step_s   = $signed({2'b0, step});
		change   = 26'(clamped) - held_ext;
		moved    = 26'(clamped);
		if (change > step_s)
			moved = held_ext + step_s;
		else if (change < -step_s)
			moved = held_ext - step_s;

		if (!cfg.limits_on)
			pos = sat[15:0];
		else if (cfg.slew_rate == 16'd0)
			pos = clamped[15:0];
		else
			pos = moved[15:0];
	end

	// round to whole degrees, half away from zero
	always_comb begin
		mag     = pos[15] ? 16'(-pos) : 16'(pos);
		mag_rnd = mag + 16'd32;
		deg_mag = mag_rnd[15:6];
		deg     = pos[15] ? $signed(-deg_mag) : $signed(deg_mag);
	end

endmodule

// File: design/servo_trim_clamp_slew_limiter.sv
// Top level of the three-channel servo trim, clamp and slew limiter.
// Depends on stcsl_pkg and stcsl_channel.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: cmd_left, cmd_right, cmd_pitch,
//           |           |                    |          elapsed_ms
//  m_       | out       | m_tvalid/m_tready  | m_tdata: pos_left, pos_right, pos_pitch,
//           |           |                    |          deg_left, deg_right, deg_pitch
//  cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle sustained while m_tready stays high; m_tvalid rises as an item
// moves from the input register to the result register. The held positions, loaded
// with the result register, feed back: the channel logic between the input and result
// registers sets the clock, with one 16x16 multiply shared by the three channels for
// the allowed step. Reset clears the valid flags, sets the held positions and registers
// to defaults. A stalled output holds a full input register and the held positions.
module servo_trim_clamp_slew_limiter (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // cmd_left[15:0], cmd_right[31:16], cmd_pitch[47:32],
	                               // elapsed_ms[63:48]
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // pos_left[15:0], pos_right[31:16], pos_pitch[47:32],
	                               // deg_left[57:48], deg_right[67:58], deg_pitch[77:68],
	                               // zero[79:78]
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	stcsl_pkg::cfg_t cfg_q;

	logic               valid_s1;
	logic signed [15:0] cmd_left_s1;
	logic signed [15:0] cmd_right_s1;
	logic signed [15:0] cmd_pitch_s1;
	logic        [15:0] elapsed_s1;

	logic signed [15:0] held_left_q;
	logic signed [15:0] held_right_q;
	logic signed [15:0] held_pitch_q;

	logic               out_valid_q;
	logic [79:0]        out_data_q;

	logic               advance;
	logic               fire;
	logic [31:0]        product;
	logic [stcsl_pkg::STEP_W-1:0] step;

	logic signed [15:0] pos_left;
	logic signed [15:0] pos_right;
	logic signed [15:0] pos_pitch;
	logic signed [9:0]  deg_left;
	logic signed [9:0]  deg_right;
	logic signed [9:0]  deg_pitch;

	// flow control: stage 1 moves when the result register is free or being taken
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neutral          <= stcsl_pkg::NEUTRAL_RST;
			cfg_q.trim_left        <= '0;
			cfg_q.trim_right       <= '0;
			cfg_q.trim_pitch       <= '0;
			cfg_q.deflection_limit <= stcsl_pkg::DEFL_LIMIT_RST;
			cfg_q.slew_rate        <= stcsl_pkg::SLEW_RATE_RST;
			cfg_q.limits_on        <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				stcsl_pkg::REG_NEUTRAL:    cfg_q.neutral          <= cfg_wdata[13:0];
				stcsl_pkg::REG_TRIM_LEFT:  cfg_q.trim_left        <= $signed(cfg_wdata[13:0]);
				stcsl_pkg::REG_TRIM_RIGHT: cfg_q.trim_right       <= $signed(cfg_wdata[13:0]);
				stcsl_pkg::REG_TRIM_PITCH: cfg_q.trim_pitch       <= $signed(cfg_wdata[13:0]);
				stcsl_pkg::REG_DEFL_LIMIT: cfg_q.deflection_limit <= cfg_wdata[12:0];
				stcsl_pkg::REG_SLEW_RATE:  cfg_q.slew_rate        <= cfg_wdata;
				stcsl_pkg::REG_LIMITS_ON:  cfg_q.limits_on        <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_left_s1  <= $signed(s_tdata[15:0]);
			cmd_right_s1 <= $signed(s_tdata[31:16]);
			cmd_pitch_s1 <= $signed(s_tdata[47:32]);
			elapsed_s1   <= s_tdata[63:48];
		end
	end

	// allowed step in 1/64 degree, shared by all channels
	assign product = cfg_q.slew_rate * elapsed_s1;
	assign step    = product[31:8];

	stcsl_channel u_left (
		.cfg  (cfg_q),
		.cmd  (cmd_left_s1),
		.trim (cfg_q.trim_left),
		.held (held_left_q),
		.step (step),
		.pos  (pos_left),
		.deg  (deg_left)
	);

	stcsl_channel u_right (
		.cfg  (cfg_q),
		.cmd  (cmd_right_s1),
		.trim (cfg_q.trim_right),
		.held (held_right_q),
		.step (step),
		.pos  (pos_right),
		.deg  (deg_right)
	);

	stcsl_channel u_pitch (
		.cfg  (cfg_q),
		.cmd  (cmd_pitch_s1),
		.trim (cfg_q.trim_pitch),
		.held (held_pitch_q),
		.step (step),
		.pos  (pos_pitch),
		.deg  (deg_pitch)
	);

	// held positions and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q  <= stcsl_pkg::HELD_RST;
			held_right_q <= stcsl_pkg::HELD_RST;
			held_pitch_q <= stcsl_pkg::HELD_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= valid_s1;
			if (fire) begin
				held_left_q  <= pos_left;
				held_right_q <= pos_right;
				held_pitch_q <= pos_pitch;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {2'b00, deg_pitch, deg_right, deg_left,
			               pos_pitch, pos_right, pos_left};
		end
	end

`ifndef SYNTH
	// a stalled result leaves the held positions untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(held_left_q) && $stable(held_right_q)
		                             && $stable(held_pitch_q)))
		else $error("held position changed while output stalled");

	// an empty result register never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with result register empty");

	// every delivered position lies within the position range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= stcsl_pkg::POS_MAX
		              && $signed(m_tdata[15:0]) >= -stcsl_pkg::POS_MAX
		              && $signed(m_tdata[31:16]) <= stcsl_pkg::POS_MAX
		              && $signed(m_tdata[31:16]) >= -stcsl_pkg::POS_MAX
		              && $signed(m_tdata[47:32]) <= stcsl_pkg::POS_MAX
		              && $signed(m_tdata[47:32]) >= -stcsl_pkg::POS_MAX))
		else $error("output position out of range");

	// a pending result is kept until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_data_q)))
		else $error("pending result lost or changed");
`endif

endmodule

// File: test/servo_trim_clamp_slew_limiter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for servo_trim_clamp_slew_limiter: stream stimulus, bit-exact predictor,
// in-order result check and several register settings. Depends on stcsl_pkg and the RTL.
module servo_trim_clamp_slew_limiter_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_ITEMS    = 104;
	localparam int RANDOM_PHASES  = 8;

	// One command transfer; first member lands in the top bits, so cmd_left sits at [15:0]
	typedef struct packed {
		logic        [15:0] elapsed_ms;
		logic signed [15:0] cmd_pitch;
		logic signed [15:0] cmd_right;
		logic signed [15:0] cmd_left;
	} servo_cmd_t;

	// One result transfer, laid out as m_tdata
	typedef struct packed {
		logic        [1:0]  pad;
		logic signed [9:0]  deg_pitch;
		logic signed [9:0]  deg_right;
		logic signed [9:0]  deg_left;
		logic signed [15:0] pos_pitch;
		logic signed [15:0] pos_right;
		logic signed [15:0] pos_left;
	} servo_pos_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = stcsl_pkg::REG_NEUTRAL;
	logic [15:0] cfg_wdata = '0;

	servo_trim_clamp_slew_limiter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Bench state
	servo_cmd_t       pending_cmds[$];
	servo_pos_t       expected_positions[$];
	stcsl_pkg::cfg_t  settings;
	int               held_pos[3];
	int               err_count = 0;
	int               result_count = 0;
	int               stall_cycles = 0;

	// Flow control knobs, changed on the falling edge only
	bit tx_steady = 1'b1;
	bit tx_pause = 1'b0;
	bit rx_steady = 1'b1;
	bit rx_long_hold = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		err_count++;
		$display("ERROR: %s", msg);
	endtask

	task automatic check_field(string name, logic signed [15:0] got, logic signed [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0d expected %0d",
				result_count, name, got, want));
	endtask

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// Trim with saturation, then clamp window and slew limit when enabled
	function automatic int limit_channel(int held, logic signed [15:0] cmd,
		logic signed [13:0] trim, logic [15:0] ms);
		int     v;
		int     lo;
		int     hi;
		longint allowed;
		longint diff;
		v = int'(cmd) + int'(trim);
		if (v > int'(stcsl_pkg::POS_MAX))
			v = int'(stcsl_pkg::POS_MAX);
		else if (v < -int'(stcsl_pkg::POS_MAX))
			v = -int'(stcsl_pkg::POS_MAX);
		if (!settings.limits_on)
			return v;
		lo = int'(settings.neutral) - int'(settings.deflection_limit);
		hi = int'(settings.neutral) + int'(settings.deflection_limit);
		if (v < lo)
			v = lo;
		else if (v > hi)
			v = hi;
		if (settings.slew_rate == 16'd0)
			return v;
		// rate is 1/16384 deg per ms, positions are 1/64 deg
		allowed = (longint'(settings.slew_rate) * longint'(ms)) >>> 8;
		diff = longint'(v) - longint'(held);
		if (diff > allowed)
			return held + int'(allowed);
		if (diff < -allowed)
			return held - int'(allowed);
		return v;
	endfunction

	// Whole degrees, half away from zero
	function automatic int round_degrees(int p);
		int mag;
		mag = (p < 0) ? -p : p;
		mag = (mag + 32) / 64;
		return (p < 0) ? -mag : mag;
	endfunction

	function automatic servo_pos_t next_positions(servo_cmd_t c);
		servo_pos_t r;
		held_pos[0] = limit_channel(held_pos[0], c.cmd_left, settings.trim_left, c.elapsed_ms);
		held_pos[1] = limit_channel(held_pos[1], c.cmd_right, settings.trim_right, c.elapsed_ms);
		held_pos[2] = limit_channel(held_pos[2], c.cmd_pitch, settings.trim_pitch, c.elapsed_ms);
		r.pad       = 2'b00;
		r.pos_left  = 16'(held_pos[0]);
		r.pos_right = 16'(held_pos[1]);
		r.pos_pitch = 16'(held_pos[2]);
		r.deg_left  = 10'(round_degrees(held_pos[0]));
		r.deg_right = 10'(round_degrees(held_pos[1]));
		r.deg_pitch = 10'(round_degrees(held_pos[2]));
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Command driver: bursts with random gaps, fed from pending_cmds
	// ---------------------------------------------------------------
	int tx_burst = 0;
	int tx_gap = 0;

	always @(posedge clk) begin
		servo_cmd_t next_cmd;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_positions.push_back(next_positions(servo_cmd_t'(s_tdata)));
			if (s_tvalid && !s_tready) begin
				// offered item must stay until its transfer
			end else if (tx_pause || tx_gap > 0 || pending_cmds.size() == 0) begin
				s_tvalid <= 1'b0;
				if (tx_gap > 0)
					tx_gap <= tx_gap - 1;
			end else begin
				next_cmd = pending_cmds.pop_front();
				s_tdata  <= next_cmd;
				s_tvalid <= 1'b1;
				if (tx_burst == 0) begin
					tx_burst <= $urandom_range(1, 24);
					tx_gap   <= tx_steady ? 0 : $urandom_range(0, 6);
				end else begin
					tx_burst <= tx_burst - 1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: rotating stall pattern, reseeded now and then, plus one long hold
	// ---------------------------------------------------------------
	logic [15:0] rx_pattern = 16'hFFFF;
	int          rx_cycle = 0;
	int          rx_hold_cnt = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_long_hold && rx_hold_cnt < LONG_HOLD) begin
				m_tready <= 1'b0;
				rx_hold_cnt++;
			end else begin
				if (!rx_long_hold)
					rx_hold_cnt = 0;
				if (rx_cycle % 97 == 0)
					rx_pattern = 16'($urandom());
				rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
				m_tready <= rx_steady || rx_pattern[0] || rx_pattern[1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		servo_pos_t got;
		servo_pos_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_positions.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					result_count));
			end else begin
				want = expected_positions.pop_front();
				check_field("pos_left", got.pos_left, want.pos_left);
				check_field("pos_right", got.pos_right, want.pos_right);
				check_field("pos_pitch", got.pos_pitch, want.pos_pitch);
				check_field("deg_left", got.deg_left, want.deg_left);
				check_field("deg_right", got.deg_right, want.deg_right);
				check_field("deg_pitch", got.deg_pitch, want.deg_pitch);
			end
			result_count++;
		end
	end

	// Watchdog: cycles without any transfer or register write
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencing helpers
	// ---------------------------------------------------------------
	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			stcsl_pkg::REG_NEUTRAL:    settings.neutral = value[13:0];
			stcsl_pkg::REG_TRIM_LEFT:  settings.trim_left = value[13:0];
			stcsl_pkg::REG_TRIM_RIGHT: settings.trim_right = value[13:0];
			stcsl_pkg::REG_TRIM_PITCH: settings.trim_pitch = value[13:0];
			stcsl_pkg::REG_DEFL_LIMIT: settings.deflection_limit = value[12:0];
			stcsl_pkg::REG_SLEW_RATE:  settings.slew_rate = value;
			stcsl_pkg::REG_LIMITS_ON:  settings.limits_on = value[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(int neu, int tl, int tr, int tp, int defl, int rate, int lim);
		write_reg(stcsl_pkg::REG_NEUTRAL, 16'(neu));
		write_reg(stcsl_pkg::REG_TRIM_LEFT, 16'(tl));
		write_reg(stcsl_pkg::REG_TRIM_RIGHT, 16'(tr));
		write_reg(stcsl_pkg::REG_TRIM_PITCH, 16'(tp));
		write_reg(stcsl_pkg::REG_DEFL_LIMIT, 16'(defl));
		write_reg(stcsl_pkg::REG_SLEW_RATE, 16'(rate));
		write_reg(stcsl_pkg::REG_LIMITS_ON, 16'(lim));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int random_trim();
		if ($urandom_range(0, 9) == 0)
			return int'($urandom_range(0, 16383)) - 8192;
		return int'($urandom_range(0, 11520)) - 5760;
	endfunction

	task automatic randomize_settings();
		int neu;
		int defl;
		int rate;
		neu  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 11520);
		defl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 5760);
		case ($urandom_range(0, 4))
			0: rate = 0;
			1: rate = $urandom_range(1, 64);
			2: rate = $urandom_range(4000, 6000);
			3: rate = $urandom_range(0, 65535);
			default: rate = 65535;
		endcase
		apply_settings(neu, random_trim(), random_trim(), random_trim(), defl, rate,
			($urandom_range(0, 3) != 0) ? 1 : 0);
	endtask

	// Commands near the clamp window or across the range, some at the extremes or any 16 bits
	function automatic logic [15:0] random_angle();
		int span;
		case ($urandom_range(0, 9))
			0: return 16'($urandom());
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'(23040);
					1: return 16'(-23040);
					2: return 16'h7FFF;
					default: return 16'h8000;
				endcase
			end
			2, 3, 4, 5: begin
				span = int'(settings.deflection_limit) + 300;
				return 16'(int'(settings.neutral) + int'($urandom_range(0, 2 * span)) - span);
			end
			default: return 16'(int'($urandom_range(0, 46080)) - 23040);
		endcase
	endfunction

	function automatic servo_cmd_t random_cmd();
		servo_cmd_t c;
		c.cmd_left  = random_angle();
		c.cmd_right = random_angle();
		c.cmd_pitch = random_angle();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: c.elapsed_ms = 16'($urandom_range(0, 8));
			6, 7: c.elapsed_ms = 16'($urandom_range(0, 300));
			8: c.elapsed_ms = 16'($urandom());
			default: c.elapsed_ms = 16'd0;
		endcase
		return c;
	endfunction

	function automatic void push_cmd(int l, int r, int p, int ms);
		pending_cmds.push_back({16'(ms), 16'(p), 16'(r), 16'(l)});
	endfunction

	// Block idle: nothing queued, offered or outstanding, pipeline drained
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || s_tvalid || expected_positions.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random_phase(bit long_hold, bit pause_midway);
		randomize_settings();
		tx_steady    = long_hold || ($urandom_range(0, 3) == 0);
		rx_steady    = !long_hold && ($urandom_range(0, 3) == 0);
		rx_long_hold = long_hold;
		repeat (PHASE_ITEMS) pending_cmds.push_back(random_cmd());
		if (pause_midway) begin
			// sender stops until every outstanding result is out
			while (pending_cmds.size() > PHASE_ITEMS / 2)
				@(negedge clk);
			tx_pause = 1'b1;
			while (s_tvalid || expected_positions.size() != 0)
				@(negedge clk);
			tx_pause = 1'b0;
		end
		wait_idle();
		rx_long_hold = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		settings.neutral          = stcsl_pkg::NEUTRAL_RST;
		settings.trim_left        = '0;
		settings.trim_right       = '0;
		settings.trim_pitch       = '0;
		settings.deflection_limit = stcsl_pkg::DEFL_LIMIT_RST;
		settings.slew_rate        = stcsl_pkg::SLEW_RATE_RST;
		settings.limits_on        = 1'b1;
		foreach (held_pos[i])
			held_pos[i] = int'(stcsl_pkg::HELD_RST);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: no move, window clamp, huge step, out-of-range commands
		push_cmd(5760, 5760, 5760, 0);
		push_cmd(23040, -23040, 0, 1);
		push_cmd(23040, -23040, 0, 65535);
		push_cmd(32767, -32768, 5760, 3);
		push_cmd(-1, 0, 8320, 2);
		wait_idle();

		// Limits off: trim saturation both ways and rounding at the half degree
		apply_settings(5760, 5760, -5760, -8192, 2560, 4915, 0);
		push_cmd(23040, -23040, 32767, 9);
		push_cmd(-5728, 5791, 8161, 0);
		push_cmd(-5792, 5727, 8159, 0);
		push_cmd(-5791, 5792, 8224, 1);
		push_cmd(-32768, -32768, -32768, 65535);
		push_cmd(0, 0, 0, 0);
		push_cmd(32767, 32767, 0, 4);
		wait_idle();

		// Zero-width window at zero, slowest rate: step is zero below 256 ms
		apply_settings(0, 0, 0, 0, 0, 1, 1);
		push_cmd(100, 100, 100, 255);
		push_cmd(100, -100, 0, 256);
		push_cmd(0, 0, 0, 65535);
		wait_idle();

		// Register values past their ranges, fastest rate
		apply_settings(16383, 8191, 8191, -8192, 8191, 65535, 1);
		push_cmd(23040, -23040, 32767, 1);
		push_cmd(0, 0, 0, 0);
		push_cmd(-23040, 23040, 0, 65535);
		wait_idle();

		// Slew limiting disabled
		apply_settings(11520, -5760, 5760, 0, 5760, 0, 1);
		push_cmd(0, 23040, 11520, 7);
		push_cmd(-23040, -23040, 23040, 0);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++)
			run_random_phase(ph == 2, ph == 5);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_positions.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_positions.size()));
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: servo_trim_clamp_slew_limiter.f
design/stcsl_pkg.sv
design/stcsl_channel.sv
design/servo_trim_clamp_slew_limiter.sv
test/servo_trim_clamp_slew_limiter_test.sv
